// File: rtl/cap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_pkg: shared types and constants
// Widths, register indexes, the descriptor word passed from the front end to
// the back end, and the back-end state type.
// ----------------------------------------------------------------------------
package cap_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = COL_W + 1;
  localparam int HGT_W      = 16;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 2;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [WID_W-1:0] MAX_WIDTH_V = WID_W'(MAX_WIDTH);

  // Floor of x / 3 for x below 1024 is (x * 683) >> 11.
  localparam int RECIP3_W     = 10;
  localparam int RECIP3_SHIFT = 11;
  localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;

  localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
  localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
  localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
  localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic [COL_W-1:0] col;
    logic             has_left;
    logic             has_up;
    logic             has_ur;
    logic             last;
  } desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UR,
    ST_SUM,
    ST_DIV
  } state_t;

endpackage

// File: rtl/causal_average_pixel_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_average_pixel_predictor_unit: causal average predictor, top level
// Encodes pixels to residuals or decodes residuals to pixels against the
// floor of the mean of the available up-left, up, up-right and left pixels.
//
//   Channel   Handshake          Word
//   input     push / full        in_sample_in
//   result    pop / empty        out_sample_out, out_frame_end
//   config    cfg_wr_en          cfg_index, cfg_data
//
// Each word passes four steps in the back end: two reads of the single-port
// line buffer, the neighbor sum and the divide with write-back.
// The back end takes no new word until the last one has been written back.
// Reset leaves the line buffer unset; no clearing pass is needed.
// The back end holds its last step while the result register is full;
// a two-word queue lets the input side keep accepting meanwhile.
// ----------------------------------------------------------------------------
module causal_average_pixel_predictor_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cap_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [cap_pkg::PIX_W-1:0]      in_sample_in,
  input  logic                           pop,
  output logic                           empty,
  output logic [cap_pkg::PIX_W-1:0]      out_sample_out,
  output logic                           out_frame_end
);
  import cap_pkg::*;

  logic             mode_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic             cfg_clear;
  logic [WID_W-1:0] eff_width;
  logic [HGT_W-1:0] eff_height;

  logic  accept;
  desc_t front_desc;
  desc_t q_head;
  logic  q_empty;
  logic  q_pop;

  assign cfg_clear = cfg_wr_en &&
                     (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
                      cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= WID_W'(1);
      height_r <= HGT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[0];
        REG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_width = WID_W'(1);
    end else if (width_r > MAX_WIDTH_V) begin
      eff_width = MAX_WIDTH_V;
    end else begin
      eff_width = width_r;
    end
    eff_height = (height_r == '0) ? HGT_W'(1) : height_r;
  end

  assign accept = push && !full;

  cap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_clear),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .accept     (accept),
    .sample     (in_sample_in),
    .desc       (front_desc)
  );

  cap_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (front_desc),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  cap_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_clear),
    .mode       (mode_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .sample_out (out_sample_out),
    .frame_end  (out_frame_end)
  );

endmodule

// File: rtl/cap_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_front: raster position tracking
// Tracks column and row, and classifies each word by which neighbors exist.
// ----------------------------------------------------------------------------
module cap_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_clear,
  input  logic [cap_pkg::WID_W-1:0]    eff_width,
  input  logic [cap_pkg::HGT_W-1:0]    eff_height,
  input  logic                         accept,
  input  logic [cap_pkg::PIX_W-1:0]    sample,
  output cap_pkg::desc_t               desc
);
  import cap_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [HGT_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] col_inc;
  logic [HGT_W:0]   row_inc;
  logic             col_wrap;
  logic             row_wrap;

  assign col_inc  = {1'b0, col_r} + WID_W'(1);
  assign row_inc  = {1'b0, row_r} + (HGT_W + 1)'(1);
  assign col_wrap = col_inc >= eff_width;
  assign row_wrap = row_inc >= {1'b0, eff_height};

  always_comb begin
    desc.sample   = sample;
    desc.col      = col_r;
    desc.has_left = col_r != '0;
    desc.has_up   = row_r != '0;
    desc.has_ur   = (row_r != '0) && (col_inc < eff_width);
    desc.last     = (col_inc == eff_width) && (row_inc == {1'b0, eff_height});
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[HGT_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: rtl/cap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_queue: two-word descriptor queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cap_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cap_pkg::desc_t wr_data,
  input  logic           rd_en,
  output cap_pkg::desc_t rd_data,
  output logic           full,
  output logic           empty
);
  import cap_pkg::*;

  desc_t      entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign rd_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/cap_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_back: prediction and line buffer
// Reads the row above from the line buffer, forms the neighbor average,
// applies it to the word and writes the true pixel back.
// ----------------------------------------------------------------------------
module cap_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_clear,
  input  logic                      mode,
  input  logic                      q_empty,
  input  cap_pkg::desc_t            q_head,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [cap_pkg::PIX_W-1:0] sample_out,
  output logic                      frame_end
);
  import cap_pkg::*;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_r;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;

  state_t state_r, state_nxt;
  desc_t  desc_r;

  logic [PIX_W-1:0] up_r;
  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] upleft_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                      load;
  logic [SUM_W+RECIP3_W-1:0] prod;
  logic [PIX_W-1:0]          pred;
  logic [PIX_W-1:0]          result;
  logic [PIX_W-1:0]          pixel;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_sample_r;
  logic             out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_UR;
        end
      end
      ST_UR:  state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!out_valid_r || pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = desc_r.col;
    load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop   = !q_empty;
        rd_en   = !q_empty;
        rd_addr = q_head.col;
      end
      ST_UR: begin
        rd_en   = 1'b1;
        rd_addr = desc_r.col + COL_W'(1);
      end
      ST_SUM: begin
      end
      ST_DIV: begin
        load = !out_valid_r || pop;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = CNT_NONE;
    if (desc_r.has_up && desc_r.has_left) begin
      sum_nxt = sum_nxt + SUM_W'(upleft_r);
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
    if (desc_r.has_up) begin
      sum_nxt = sum_nxt + SUM_W'(up_r);
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
    if (desc_r.has_ur) begin
      sum_nxt = sum_nxt + SUM_W'(rd_data_r);
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
    if (desc_r.has_left) begin
      sum_nxt = sum_nxt + SUM_W'(left_r);
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
  end

  assign prod = sum_r * RECIP3;

  always_comb begin
    unique case (cnt_r)
      CNT_ONE:   pred = sum_r[PIX_W-1:0];
      CNT_TWO:   pred = sum_r[PIX_W:1];
      CNT_THREE: pred = prod[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
      CNT_FOUR:  pred = sum_r[PIX_W+1:2];
      default:   pred = '0;
    endcase
  end

  always_comb begin
    if (cnt_r == CNT_NONE) begin
      result = desc_r.sample;
    end else if (mode) begin
      result = desc_r.sample + pred;
    end else begin
      result = desc_r.sample - pred;
    end
    pixel = mode ? result : desc_r.sample;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
    if (load) begin
      line_mem[desc_r.col] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
    if (state_r == ST_UR) begin
      up_r <= rd_data_r;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    if (load) begin
      out_sample_r <= result;
      out_last_r   <= desc_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      upleft_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_clear) begin
        left_r   <= '0;
        upleft_r <= '0;
      end else if (load) begin
        left_r   <= pixel;
        upleft_r <= desc_r.has_up ? up_r : '0;
      end
    end
  end

  assign empty      = !out_valid_r;
  assign sample_out = out_sample_r;
  assign frame_end  = out_last_r;

endmodule

// File: dv/cap_residual_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_residual_check: prediction and comparison for the pixel predictor
// Watches the configuration port and both word channels of the causal
// average predictor. It keeps its own line buffer, neighbor registers and
// raster position, works out the residual or reconstructed pixel for every
// accepted input word, and compares each accepted result word against the
// oldest expected one.
// ----------------------------------------------------------------------------
module cap_residual_check
  import cap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic                  full,
  input  logic [PIX_W-1:0]      in_sample_in,
  input  logic                  pop,
  input  logic                  empty,
  input  logic [PIX_W-1:0]      out_sample_out,
  input  logic                  out_frame_end,
  output int                    mismatches,
  output int                    words_pending,
  output int                    frames_closed
);

  localparam logic MODE_ENCODE = 1'b0;

  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic             frame_end;
  } coded_word_t;

  coded_word_t      expected_q[$];
  bit [PIX_W-1:0]   line_buf [MAX_WIDTH];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] upleft_px;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      words_checked;
  logic             mode_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;

  initial begin
    mismatches    = 0;
    words_pending = 0;
    frames_closed = 0;
    words_checked = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH on result word %0d: %s", $time, words_checked, what);
  endtask

  task automatic code_pixel(input logic [PIX_W-1:0] sample, output coded_word_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      sum;
    int unsigned      cnt;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] coded;
    logic [PIX_W-1:0] px;
    w = (width_r == 0) ? 1 : ((width_r > MAX_WIDTH) ? MAX_WIDTH : width_r);
    h = (height_r == 0) ? 1 : height_r;
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    sum = 0;
    cnt = 0;
    up  = '0;
    if (r > 0) begin
      up = line_buf[c];
      if (c > 0) begin
        sum += upleft_px;
        cnt++;
      end
      sum += up;
      cnt++;
      if (c + 1 < w) begin
        sum += line_buf[c + 1];
        cnt++;
      end
    end
    if (c > 0) begin
      sum += left_px;
      cnt++;
    end
    if (cnt == 0) begin
      coded = sample;
    end else if (mode_r == MODE_ENCODE) begin
      coded = PIX_W'(sample - sum / cnt);
    end else begin
      coded = PIX_W'(sample + sum / cnt);
    end
    px = (mode_r == MODE_ENCODE) ? sample : coded;
    upleft_px   = up;
    line_buf[c] = px;
    left_px     = px;
    res.sample    = coded;
    res.frame_end = (c + 1 == w) && (r + 1 == h);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    coded_word_t got;
    coded_word_t want;
    coded_word_t predicted;
    logic        restart;
    if (!rst_n) begin
      expected_q.delete();
      left_px   = '0;
      upleft_px = '0;
      col_pos   = 0;
      row_pos   = 0;
      mode_r    = MODE_ENCODE;
      width_r   = WID_W'(1);
      height_r  = HGT_W'(1);
    end else begin
      if (cfg_wr_en) begin
        restart = 1'b1;
        case (cfg_index)
          REG_MODE:   mode_r = cfg_data[0];
          REG_WIDTH:  width_r = cfg_data[WID_W-1:0];
          REG_HEIGHT: height_r = cfg_data[HGT_W-1:0];
          default:    restart = 1'b0;
        endcase
        if (restart) begin
          col_pos   = 0;
          row_pos   = 0;
          left_px   = '0;
          upleft_px = '0;
        end
      end
      if (pop && !empty) begin
        got.sample    = out_sample_out;
        got.frame_end = out_frame_end;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word sample=%02h frame_end=%b",
                                    got.sample, got.frame_end));
        end else begin
          want = expected_q.pop_front();
          if (got.sample !== want.sample) begin
            report_mismatch($sformatf("sample_out %02h, expected %02h",
                                      got.sample, want.sample));
          end
          if (got.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      got.frame_end, want.frame_end));
          end
          if (want.frame_end) frames_closed++;
        end
        words_checked++;
      end
      if (push && !full) begin
        code_pixel(in_sample_in, predicted);
        expected_q.push_back(predicted);
      end
    end
    words_pending = expected_q.size();
  end

endmodule

// File: dv/causal_average_pixel_predictor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_average_pixel_predictor_unit_tb: testbench top for the predictor
// Drives reset, register writes and pixel or residual words, pops results
// with random stalls and one long hold-off, and reports the verdict from the
// mismatch and pending counts of the residual checker. A watchdog ends the
// run when no word moves for too long.
// ----------------------------------------------------------------------------
module causal_average_pixel_predictor_unit_tb;
  import cap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_WORDS  = 1700;
  localparam int CLAMP_WORDS   = 40;
  localparam int PHASE_CAP     = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  logic [PIX_W-1:0]      in_sample_in;
  logic                  pop;
  logic                  empty;
  logic [PIX_W-1:0]      out_sample_out;
  logic                  out_frame_end;

  int               mismatches;
  int               words_pending;
  int               frames_closed;
  int               words_sent;
  int               random_sent;
  int               geometries;
  int               holds_done;
  int               idle_cycles;
  logic             tx_idle_on;
  logic             rx_idle_on;
  logic             hold_pending;
  logic [PIX_W-1:0] last_sample;

  causal_average_pixel_predictor_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_sample_in   (in_sample_in),
    .pop            (pop),
    .empty          (empty),
    .out_sample_out (out_sample_out),
    .out_frame_end  (out_frame_end)
  );

  cap_residual_check residual_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_sample_in   (in_sample_in),
    .pop            (pop),
    .empty          (empty),
    .out_sample_out (out_sample_out),
    .out_frame_end  (out_frame_end),
    .mismatches     (mismatches),
    .words_pending  (words_pending),
    .frames_closed  (frames_closed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [PIX_W-1:0] pick_sample();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3, 4: v = last_sample + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
      default: v = PIX_W'($urandom);
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic m, input int unsigned w, input int unsigned h);
    cfg_write(REG_MODE, {15'($urandom), m});
    cfg_write(REG_WIDTH, {3'($urandom), 13'(w)});
    cfg_write(REG_HEIGHT, 16'(h));
    geometries++;
  endtask

  task automatic send_word(input logic [PIX_W-1:0] value);
    while (tx_idle_on && $urandom_range(0, 99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_sample_in <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    wait (words_pending == 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int          phase;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    push         = 1'b0;
    in_sample_in = '0;
    pop          = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_pending = 1'b0;
    last_sample  = '0;
    words_sent   = 0;
    random_sent  = 0;
    geometries   = 0;
    holds_done   = 0;
    phase        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry is a one-pixel frame in encode mode.
    send_word(8'hA5);
    send_word(8'h5A);
    drain();
    for (int m = 0; m < 2; m++) begin
      set_geometry(m[0], 3, 3);
      for (int k = 0; k < 9; k++) send_word(((k + m) % 2) ? 8'h00 : 8'hFF);
      drain();
    end
    set_geometry(1'b0, 0, 0);
    send_word(8'h3C);
    send_word(8'hC3);
    drain();

    // A width beyond the line buffer is clamped.
    set_geometry(1'($urandom), 13'h1FFF, 1);
    repeat (CLAMP_WORDS) send_word(pick_sample());
    drain();
    set_geometry(1'($urandom), MAX_WIDTH, 16'hFFFF);
    repeat (60) send_word(pick_sample());
    drain();

    while (random_sent < RANDOM_WORDS) begin
      phase++;
      case ($urandom_range(0, 19))
        0:       w = 0;
        19:      w = $urandom_range(65, 300);
        15, 16, 17, 18: w = $urandom_range(9, 64);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = 16'hFFFF;
        default: h = $urandom_range(1, 6);
      endcase
      set_geometry(1'($urandom), w, h);
      if ($urandom_range(0, 5) == 0) cfg_write(REG_SPARE, 16'($urandom));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      n = $urandom_range(1, 3) * w * h;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w);
      if (n > PHASE_CAP || phase == 2 || phase == 4) n = PHASE_CAP;
      tx_idle_on = (phase != 4);
      rx_idle_on = (phase != 4);
      if (phase == 2) hold_pending = 1'b1;
      repeat (n) send_word(pick_sample());
      random_sent += n;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run summary: %0d words in %0d register settings, %0d frames closed,",
             words_sent, geometries, frames_closed);
    $display("encode and decode, widths 1 to the clamped maximum, %0d long receiver hold-off.",
             holds_done);
    if (mismatches == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        holds_done++;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= !(rx_idle_on && $urandom_range(0, 99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding.",
               STALL_LIMIT, words_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
